>>> rtl/core/opu_pkg.sv
// Shared constants for the order packet unstuffing and traded total block.
`timescale 1ns / 1ps

package opu_pkg;

  // Default sizes of the unstuffed word and of the scanned packet
  localparam int DECODED_BITS_DEF = 49;
  localparam int PACKET_BITS_DEF  = 64;

  // Packet bits handled by one scan stage
  localparam int BITS_PER_STAGE = 8;

  // A run of this many ones drops the following packet bit
  localparam logic [2:0] RUN_LIMIT = 3'd5;

  // Field layout of the unstuffed word
  localparam int STOCK_W   = 32;
  localparam int SELL_BIT  = 32;
  localparam int QTY_LSB   = 33;
  localparam int QTY_W     = 8;
  localparam int PRICE_LSB = 41;
  localparam int PRICE_W   = 8;
  localparam int PROD_W    = QTY_W + PRICE_W;

  // Running total width and saturation value
  localparam int                 TOTAL_W   = 63;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

>>> rtl/core/opu_scan_stage.sv
// One pipeline stage of the unstuffing scan: handles up to eight packet bits.
`timescale 1ns / 1ps

module opu_scan_stage #(
  parameter int STAGE_IDX    = 0,
  parameter int PACKET_BITS  = opu_pkg::PACKET_BITS_DEF,
  parameter int DECODED_BITS = opu_pkg::DECODED_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    up_valid,
  output logic                                    up_stall,
  input  logic [PACKET_BITS-1:0]                  up_packet,
  input  logic                                    up_first,
  input  logic [DECODED_BITS-1:0]                 up_word,
  input  logic [$clog2(DECODED_BITS+1)-1:0]       up_pos,
  input  logic [2:0]                              up_ones,
  input  logic                                    up_skip,
  output logic                                    dn_valid,
  input  logic                                    dn_stall,
  output logic [PACKET_BITS-1:0]                  dn_packet,
  output logic                                    dn_first,
  output logic [DECODED_BITS-1:0]                 dn_word,
  output logic [$clog2(DECODED_BITS+1)-1:0]       dn_pos,
  output logic [2:0]                              dn_ones,
  output logic                                    dn_skip
);
  import opu_pkg::*;

  localparam int POS_W = $clog2(DECODED_BITS + 1);
  localparam int IDX_W = $clog2(DECODED_BITS);

  logic                    valid_r, valid_nxt;
  logic                    load;
  logic [PACKET_BITS-1:0]  packet_r;
  logic                    first_r;
  logic [DECODED_BITS-1:0] word_r, word_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [2:0]              ones_r, ones_nxt;
  logic                    skip_r, skip_nxt;

  // Handshake: take a new item when empty or when the held item leaves
  assign up_stall  = valid_r && dn_stall;
  assign load      = up_valid && !up_stall;
  assign valid_nxt = up_stall ? valid_r : up_valid;

  // Walk this stage's packet bits in order, copying or dropping each one
  always_comb begin
    int                  idx;
    logic [DECODED_BITS-1:0] w;
    logic [POS_W-1:0]    p;
    logic [2:0]          o;
    logic                s;
    logic                b;
    w = up_word;
    p = up_pos;
    o = up_ones;
    s = up_skip;
    for (int k = 0; k < BITS_PER_STAGE; k++) begin
      idx = STAGE_IDX * BITS_PER_STAGE + k;
      if (idx < PACKET_BITS) begin
        b = up_packet[idx];
        if (s) begin
          // drop the bit after a full run of ones
          s = 1'b0;
        end else if (p < POS_W'(DECODED_BITS)) begin
          w[p[IDX_W-1:0]] = b;
          p = p + POS_W'(1);
          if (b) begin
            if (o == RUN_LIMIT - 3'd1) begin
              o = 3'd0;
              s = 1'b1;
            end else begin
              o = o + 3'd1;
            end
          end else begin
            o = 3'd0;
          end
        end
      end
    end
    word_nxt = w;
    pos_nxt  = p;
    ones_nxt = o;
    skip_nxt = s;
  end

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload: capture on load, hold otherwise
  always_ff @(posedge clk) begin
    if (load) begin
      packet_r <= up_packet;
      first_r  <= up_first;
      word_r   <= word_nxt;
      pos_r    <= pos_nxt;
      ones_r   <= ones_nxt;
      skip_r   <= skip_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign dn_packet = packet_r;
  assign dn_first  = first_r;
  assign dn_word   = word_r;
  assign dn_pos    = pos_r;
  assign dn_ones   = ones_r;
  assign dn_skip   = skip_r;

endmodule

>>> rtl/core/opu_total.sv
// Field split, quantity times price, and the saturating running total.
`timescale 1ns / 1ps

module opu_total #(
  parameter int DECODED_BITS = opu_pkg::DECODED_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_stall,
  input  logic [DECODED_BITS-1:0]       up_word,
  input  logic                          up_first,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [opu_pkg::STOCK_W-1:0]   out_stock_id,
  output logic                          out_is_sell,
  output logic [opu_pkg::QTY_W-1:0]     out_quantity,
  output logic [opu_pkg::PRICE_W-1:0]   out_price,
  output logic [opu_pkg::TOTAL_W-1:0]   out_running_total
);
  import opu_pkg::*;

  // Product stage
  logic               pv_r, pv_nxt;
  logic               p_stall, p_load;
  logic [STOCK_W-1:0] p_stock_r;
  logic               p_sell_r;
  logic [QTY_W-1:0]   p_qty_r;
  logic [PRICE_W-1:0] p_price_r;
  logic               p_first_r;
  logic [PROD_W-1:0]  p_prod_r;

  // Result stage
  logic               ov_r, ov_nxt;
  logic               o_stall, o_load;
  logic [STOCK_W-1:0] o_stock_r;
  logic               o_sell_r;
  logic [QTY_W-1:0]   o_qty_r;
  logic [PRICE_W-1:0] o_price_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W:0]   sum;

  // Product stage handshake
  assign p_stall  = pv_r && o_stall;
  assign up_stall = p_stall;
  assign p_load   = up_valid && !p_stall;
  assign pv_nxt   = p_stall ? pv_r : up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= pv_nxt;
    end
  end

  // Split the word and form quantity times price
  always_ff @(posedge clk) begin
    if (p_load) begin
      p_stock_r <= up_word[STOCK_W-1:0];
      p_sell_r  <= up_word[SELL_BIT];
      p_qty_r   <= up_word[QTY_LSB +: QTY_W];
      p_price_r <= up_word[PRICE_LSB +: PRICE_W];
      p_first_r <= up_first;
      p_prod_r  <= PROD_W'(up_word[QTY_LSB +: QTY_W]) * PROD_W'(up_word[PRICE_LSB +: PRICE_W]);
    end
  end

  // Result stage handshake
  assign o_stall = ov_r && out_stall;
  assign o_load  = pv_r && !o_stall;
  assign ov_nxt  = o_stall ? ov_r : pv_r;

  // Clear on a batch start, add, saturate on carry out of the top bit
  always_comb begin
    base      = p_first_r ? '0 : total_r;
    sum       = {1'b0, base} + (TOTAL_W + 1)'(p_prod_r);
    total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      total_r <= '0;
    end else begin
      ov_r <= ov_nxt;
      if (o_load) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_stock_r <= p_stock_r;
      o_sell_r  <= p_sell_r;
      o_qty_r   <= p_qty_r;
      o_price_r <= p_price_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_stock_id      = o_stock_r;
  assign out_is_sell       = o_sell_r;
  assign out_quantity      = o_qty_r;
  assign out_price         = o_price_r;
  assign out_running_total = total_r;

endmodule

>>> rtl/core/order_packet_unstuff_total_core.sv
// Top level: unstuffing scan pipeline followed by the traded total stages.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_packet, in_first_of_batch
//  out      output     out_valid/out_stall out_stock_id, out_is_sell, out_quantity,
//                                          out_price, out_running_total
//
// One item enters per cycle while in_stall is low; each item passes through the
// eight-bit scan stages, then the multiply stage and the accumulate stage.
// Synchronous active-low reset empties the pipeline and clears the running total.
// out_stall holds the last stage; in_stall rises only when every stage is full.
`timescale 1ns / 1ps

module order_packet_unstuff_total_core #(
  parameter int DECODED_BITS = opu_pkg::DECODED_BITS_DEF,
  parameter int PACKET_BITS  = opu_pkg::PACKET_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PACKET_BITS-1:0]        in_packet,
  input  logic                          in_first_of_batch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [opu_pkg::STOCK_W-1:0]   out_stock_id,
  output logic                          out_is_sell,
  output logic [opu_pkg::QTY_W-1:0]     out_quantity,
  output logic [opu_pkg::PRICE_W-1:0]   out_price,
  output logic [opu_pkg::TOTAL_W-1:0]   out_running_total
);
  import opu_pkg::*;

  localparam int SCAN_STAGES = (PACKET_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int POS_W       = $clog2(DECODED_BITS + 1);

  logic                    v_s     [SCAN_STAGES+1];
  logic                    st_s    [SCAN_STAGES+1];
  logic [PACKET_BITS-1:0]  pk_s    [SCAN_STAGES+1];
  logic                    fb_s    [SCAN_STAGES+1];
  logic [DECODED_BITS-1:0] w_s     [SCAN_STAGES+1];
  logic [POS_W-1:0]        pos_s   [SCAN_STAGES+1];
  logic [2:0]              ones_s  [SCAN_STAGES+1];
  logic                    skip_s  [SCAN_STAGES+1];

  // Feed the first scan stage with an empty word
  assign v_s[0]    = in_valid;
  assign in_stall  = st_s[0];
  assign pk_s[0]   = in_packet;
  assign fb_s[0]   = in_first_of_batch;
  assign w_s[0]    = '0;
  assign pos_s[0]  = '0;
  assign ones_s[0] = 3'd0;
  assign skip_s[0] = 1'b0;

  // Scan pipeline
  for (genvar g = 0; g < SCAN_STAGES; g++) begin : g_scan
    opu_scan_stage #(
      .STAGE_IDX    (g),
      .PACKET_BITS  (PACKET_BITS),
      .DECODED_BITS (DECODED_BITS)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (v_s[g]),
      .up_stall  (st_s[g]),
      .up_packet (pk_s[g]),
      .up_first  (fb_s[g]),
      .up_word   (w_s[g]),
      .up_pos    (pos_s[g]),
      .up_ones   (ones_s[g]),
      .up_skip   (skip_s[g]),
      .dn_valid  (v_s[g+1]),
      .dn_stall  (st_s[g+1]),
      .dn_packet (pk_s[g+1]),
      .dn_first  (fb_s[g+1]),
      .dn_word   (w_s[g+1]),
      .dn_pos    (pos_s[g+1]),
      .dn_ones   (ones_s[g+1]),
      .dn_skip   (skip_s[g+1])
    );
  end

  // Product and running total
  opu_total #(
    .DECODED_BITS (DECODED_BITS)
  ) u_total (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (v_s[SCAN_STAGES]),
    .up_stall          (st_s[SCAN_STAGES]),
    .up_word           (w_s[SCAN_STAGES]),
    .up_first          (fb_s[SCAN_STAGES]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_stock_id      (out_stock_id),
    .out_is_sell       (out_is_sell),
    .out_quantity      (out_quantity),
    .out_price         (out_price),
    .out_running_total (out_running_total)
  );

endmodule

>>> rtl/core/opu_chk.sv
// Port checker for the order packet unstuffing core, bound to the top level.
`timescale 1ns / 1ps

module opu_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [opu_pkg::STOCK_W-1:0]   out_stock_id,
  input logic                          out_is_sell,
  input logic [opu_pkg::QTY_W-1:0]     out_quantity,
  input logic [opu_pkg::PRICE_W-1:0]   out_price,
  input logic [opu_pkg::TOTAL_W-1:0]   out_running_total
);
  import opu_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_stock_id) && $stable(out_is_sell)
      && $stable(out_quantity) && $stable(out_price) && $stable(out_running_total))
    else $error("stalled result changed");

  // Drop a result only after it was taken
  a_out_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result withdrawn without being taken");

  // Stall the input only when the pipeline is full behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output side is free");

  // A nonzero trade leaves a nonzero total
  a_total_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_quantity != '0 && out_price != '0 |-> out_running_total != '0)
    else $error("running total zero after a nonzero trade");

endmodule

bind order_packet_unstuff_total_core opu_chk u_opu_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_stock_id      (out_stock_id),
  .out_is_sell       (out_is_sell),
  .out_quantity      (out_quantity),
  .out_price         (out_price),
  .out_running_total (out_running_total)
);
